// ===== rtl/radix_number_parser_core_defines.svh =====
// ---------------------------------------------------------------------------
// radix number parser assertion macros
// concurrent assertion helpers used by radix_number_parser_core
// ---------------------------------------------------------------------------
`ifndef RADIX_NUMBER_PARSER_CORE_DEFINES_SVH
`define RADIX_NUMBER_PARSER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RNP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rnp assertion failed");

// next-cycle implication, checked outside reset
`define RNP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rnp assertion failed");

`endif

// ===== rtl/rnp_pkg.sv =====
// ---------------------------------------------------------------------------
// rnp_pkg
// shared widths, character codes and parser state type
// ---------------------------------------------------------------------------
`default_nettype none

package rnp_pkg;

    localparam int CHAR_W      = 8;
    localparam int VALUE_W     = 64;
    localparam int CONS_W      = 8;
    localparam int RADIX_W     = 6;
    localparam int DIGIT_W     = 6;
    localparam int MAX_LEN     = 255;
    localparam int POS_W       = $clog2(MAX_LEN + 1);
    localparam int CONS_MAX    = (2 ** CONS_W) - 1;

    localparam int RADIX_MIN   = 2;
    localparam int RADIX_MAX   = 36;
    localparam int RADIX_RESET = 10;
    localparam int DIGIT_BAD   = 37;
    localparam int DIGIT_ALPHA = 10;

    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic [POS_W-1:0]   pos;
        logic               neg;
        logic               stopped;
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/rnp_char_if.sv =====
// ---------------------------------------------------------------------------
// rnp_char_if
// character channel: valid, ready, character code and last flag
// ---------------------------------------------------------------------------
`default_nettype none

interface rnp_char_if;
    import rnp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/rnp_result_if.sv =====
// ---------------------------------------------------------------------------
// rnp_result_if
// result channel: valid, ready, parsed value and consumed count
// ---------------------------------------------------------------------------
`default_nettype none

interface rnp_result_if;
    import rnp_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [CONS_W-1:0]  consumed;

    modport source (output valid, output value, output consumed, input ready);
    modport sink   (input valid, input value, input consumed, output ready);
endinterface

`default_nettype wire

// ===== rtl/rnp_step.sv =====
// ---------------------------------------------------------------------------
// rnp_step
// one character step: digit decode, sign handling and multiply-accumulate
// ---------------------------------------------------------------------------
`default_nettype none

module rnp_step (
    input  rnp_pkg::t_state                 i_state,
    input  logic [rnp_pkg::CHAR_W-1:0]      i_char_code,
    input  logic                            i_is_last,
    input  logic [rnp_pkg::RADIX_W-1:0]     i_radix,
    output rnp_pkg::t_state                 o_state,
    output logic [rnp_pkg::VALUE_W-1:0]     o_value,
    output logic [rnp_pkg::CONS_W-1:0]      o_consumed
);
    import rnp_pkg::*;

    logic [DIGIT_W-1:0]   digit;
    logic [VALUE_W-1:0]   digit_ext;
    logic [37:0]          prod_lo;
    logic [31:0]          prod_hi;
    logic [VALUE_W-1:0]   mac;
    t_state               s;

    always_comb begin
        if (i_char_code inside {[CH_0:CH_9]}) begin
            digit = DIGIT_W'(i_char_code - CH_0);
        end else if (i_char_code inside {[CH_UA:CH_UZ]}) begin
            digit = DIGIT_W'(i_char_code - CH_UA) + DIGIT_W'(DIGIT_ALPHA);
        end else if (i_char_code inside {[CH_LA:CH_LZ]}) begin
            digit = DIGIT_W'(i_char_code - CH_LA) + DIGIT_W'(DIGIT_ALPHA);
        end else begin
            digit = DIGIT_W'(DIGIT_BAD);
        end
    end

    // negative strings accumulate downward so the result needs no negation
    assign digit_ext = i_state.neg ? (VALUE_W'(0) - VALUE_W'(digit)) : VALUE_W'(digit);
    assign prod_lo   = i_state.acc[31:0] * i_radix;
    assign prod_hi   = 32'(i_state.acc[63:32] * i_radix);
    assign mac       = {prod_hi + 32'(prod_lo[37:32]), prod_lo[31:0]} + digit_ext;

    always_comb begin
        s = i_state;
        if (!i_state.stopped) begin
            if (i_state.pos == '0 && (i_char_code == CH_PLUS || i_char_code == CH_MINUS)) begin
                s.neg = (i_char_code == CH_MINUS);
                if (32'(i_state.pos) < 32'(MAX_LEN)) begin
                    s.pos = i_state.pos + 1'b1;
                end
            end else if (digit >= i_radix) begin
                s.stopped = 1'b1;
            end else begin
                s.acc = mac;
                if (32'(i_state.pos) < 32'(MAX_LEN)) begin
                    s.pos = i_state.pos + 1'b1;
                end
            end
        end
    end

    assign o_value    = s.acc;
    assign o_consumed = (32'(s.pos) > 32'(CONS_MAX)) ? CONS_W'(CONS_MAX) : CONS_W'(s.pos);
    assign o_state    = i_is_last ? t_state'('0) : s;

endmodule

`default_nettype wire

// ===== rtl/radix_number_parser_core.sv =====
// ---------------------------------------------------------------------------
// radix_number_parser_core
// streaming ascii to integer conversion in a configurable base 2..36
// result path: a last character is held in the input register, then its result is registered when the output is free
// throughput: one character per cycle unless a last character waits on a busy result, set by the multiply-add loop
// reset: synchronous active low, radix returns to 10 and string state clears
// ---------------------------------------------------------------------------
`default_nettype none
`include "radix_number_parser_core_defines.svh"

module radix_number_parser_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rnp_pkg::RADIX_W-1:0]     i_cfg_wdata,
    rnp_char_if.sink                        i_char,
    rnp_result_if.source                    o_result
);
    import rnp_pkg::*;

    logic [RADIX_W-1:0] r_radix;
    logic [RADIX_W-1:0] n_radix;
    logic               r_in_valid;
    logic [CHAR_W-1:0]  r_in_char;
    logic               r_in_last;
    t_state             r_state;
    t_state             n_state;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic [CONS_W-1:0]  r_out_consumed;
    logic [VALUE_W-1:0] n_value;
    logic [CONS_W-1:0]  n_consumed;

    logic out_free;
    logic adv;
    logic in_take;

    assign out_free = !r_out_valid || o_result.ready;
    assign adv      = r_in_valid && (!r_in_last || out_free);
    assign i_char.ready = !r_in_valid || adv;
    assign in_take  = i_char.valid && i_char.ready;

    // out-of-range bases are clamped at write time
    always_comb begin
        if (i_cfg_wdata < RADIX_W'(RADIX_MIN)) begin
            n_radix = RADIX_W'(RADIX_MIN);
        end else if (i_cfg_wdata > RADIX_W'(RADIX_MAX)) begin
            n_radix = RADIX_W'(RADIX_MAX);
        end else begin
            n_radix = i_cfg_wdata;
        end
    end

    rnp_step u_step (
        .i_state     (r_state),
        .i_char_code (r_in_char),
        .i_is_last   (r_in_last),
        .i_radix     (r_radix),
        .o_state     (n_state),
        .o_value     (n_value),
        .o_consumed  (n_consumed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix     <= RADIX_W'(RADIX_RESET);
            r_in_valid  <= 1'b0;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_radix <= n_radix;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_state <= n_state;
            end
            if (adv && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= i_char.char_code;
            r_in_last <= i_char.is_last;
        end
        if (adv && r_in_last) begin
            r_out_value    <= n_value;
            r_out_consumed <= n_consumed;
        end
    end

    assign o_result.valid    = r_out_valid;
    assign o_result.value    = r_out_value;
    assign o_result.consumed = r_out_consumed;

    `RNP_ASSERT_IMPL(a_radix_range, i_clk, i_rst_n, 1'b1, r_radix >= RADIX_W'(RADIX_MIN) && r_radix <= RADIX_W'(RADIX_MAX))
    `RNP_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_in_valid && !adv, r_in_valid && $stable(r_in_char) && $stable(r_in_last))
    `RNP_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, adv && r_in_last, r_out_valid)
    `RNP_ASSERT_NEXT(a_last_clears_state, i_clk, i_rst_n, adv && r_in_last, r_state.pos == '0 && !r_state.stopped && !r_state.neg)

endmodule

`default_nettype wire
